### sv/qrm_pkg.sv
package qrm_pkg;

	localparam int QW = 16;
	localparam int NW = 33;
	localparam int QBITS = 16;
	localparam logic [QW-1:0] MIN_NORM_RST = 16'd16;
	localparam logic [QBITS-1:0] ONE_Q14 = 16'd16384;

	typedef struct packed {
		logic signed [QW-1:0] quat_w;
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic valid_res;
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
	} mat_t;

endpackage

### sv/qrm_div.sv
module qrm_div (
	input  logic                    clk,
	input  logic signed [34:0]      num,
	input  logic [qrm_pkg::NW-1:0]  den,
	output logic signed [15:0]      res
);
	import qrm_pkg::*;

	localparam int ST = QBITS + 1;

	logic [NW:0]    rem_q [ST+1];
	logic [NW:0]    d2_q  [ST+1];
	logic [QBITS:0] quo_q [ST+1];
	logic           neg_q [ST+1];

	logic [34:0] mag;
	assign mag = num[34] ? 35'(-num) : num;

	always_comb begin
		rem_q[0] = (NW+1)'(mag);
		d2_q[0]  = {1'b0, den};
		quo_q[0] = '0;
		neg_q[0] = num[34];
	end

	genvar g;
	generate
		for (g = 0; g < ST; g++) begin : g_st
			logic [NW+1:0] tr;
			logic [NW+1:0] sh;
			logic          ge;
			always_comb begin
				if (g == 0)
					sh = {1'b0, rem_q[g]};
				else
					sh = {rem_q[g], 1'b0};
				tr = sh - {1'b0, d2_q[g]};
				ge = (sh >= {1'b0, d2_q[g]});
			end
			always_ff @(posedge clk) begin
				rem_q[g+1] <= ge ? tr[NW:0] : sh[NW:0];
				quo_q[g+1] <= {quo_q[g][QBITS-1:0], ge};
				d2_q[g+1]  <= d2_q[g];
				neg_q[g+1] <= neg_q[g];
			end
		end
	endgenerate

	// quotient has 16 fraction bits, round half away to 14
	logic [QBITS:0] rq;
	logic [QBITS:0] mq;
	always_comb begin
		rq  = quo_q[ST] + (QBITS+1)'(2);
		mq  = {2'b00, rq[QBITS:2]};
		mq  = (mq > {1'b0, ONE_Q14}) ? {1'b0, ONE_Q14} : mq;
		res = neg_q[ST] ? 16'(-mq) : 16'(mq);
	end

endmodule

### sv/quaternion_to_rotation_matrix_top.sv
// a request passes stage 1 (products), stage 2 (sums), the divide pipeline and the output register
// throughput: one request per cycle, busy is always low
// divide pipeline of 17 restoring steps sets the latency
// the receiver cannot stall; results are shown for one cycle only
// asynchronous active-low reset clears the pipeline valid bits and done, and sets min_norm to 16
module quaternion_to_rotation_matrix_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  qrm_pkg::quat_t quat,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,
	output logic           done,
	output qrm_pkg::mat_t  result
);
	import qrm_pkg::*;

	localparam int ST = QBITS + 1;
	localparam int DL = ST;

	logic [QW-1:0] min_norm_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_norm_q <= MIN_NORM_RST;
		else if (cfg_we) min_norm_q <= cfg_wdata;
	end

	assign busy = 1'b0;

	// stage 1: products
	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic [31:0] m2_s1;
	logic v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		ww_s1 <= quat.quat_w * quat.quat_w;
		xx_s1 <= quat.quat_x * quat.quat_x;
		yy_s1 <= quat.quat_y * quat.quat_y;
		zz_s1 <= quat.quat_z * quat.quat_z;
		xy_s1 <= quat.quat_x * quat.quat_y;
		wz_s1 <= quat.quat_w * quat.quat_z;
		xz_s1 <= quat.quat_x * quat.quat_z;
		wy_s1 <= quat.quat_w * quat.quat_y;
		yz_s1 <= quat.quat_y * quat.quat_z;
		wx_s1 <= quat.quat_w * quat.quat_x;
		m2_s1 <= min_norm_q * min_norm_q;
	end

	// stage 2: sums
	logic [NW-1:0] n2_s2;
	logic signed [34:0] num_s2 [9];
	logic ok_s2, v_s2;
	logic [NW-1:0] n2c;
	always_comb n2c = NW'(ww_s1) + NW'(xx_s1) + NW'(yy_s1) + NW'(zz_s1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		n2_s2 <= (n2c == '0) ? NW'(1) : n2c;
		ok_s2 <= (n2c != '0) && (n2c >= NW'(m2_s1));
		num_s2[0] <= 35'(ww_s1) + 35'(xx_s1) - 35'(yy_s1) - 35'(zz_s1);
		num_s2[1] <= (35'(xy_s1) - 35'(wz_s1)) <<< 1;
		num_s2[2] <= (35'(xz_s1) + 35'(wy_s1)) <<< 1;
		num_s2[3] <= (35'(xy_s1) + 35'(wz_s1)) <<< 1;
		num_s2[4] <= 35'(ww_s1) - 35'(xx_s1) + 35'(yy_s1) - 35'(zz_s1);
		num_s2[5] <= (35'(yz_s1) - 35'(wx_s1)) <<< 1;
		num_s2[6] <= (35'(xz_s1) - 35'(wy_s1)) <<< 1;
		num_s2[7] <= (35'(yz_s1) + 35'(wx_s1)) <<< 1;
		num_s2[8] <= 35'(ww_s1) - 35'(xx_s1) - 35'(yy_s1) + 35'(zz_s1);
	end

	// dividers, quotient with 16 fraction bits, rounded to 14 at the end
	logic signed [15:0] r [9];
	genvar k;
	generate
		for (k = 0; k < 9; k++) begin : g_div
			logic signed [34:0] nsh;
			assign nsh = num_s2[k];
			qrm_div u_div (.clk(clk), .num(nsh), .den(n2_s2), .res(r[k]));
		end
	endgenerate

	logic [DL-1:0] vd_q, okd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_q  <= '0;
			okd_q <= '0;
		end else begin
			vd_q  <= {vd_q[DL-2:0], v_s2};
			okd_q <= {okd_q[DL-2:0], ok_s2};
		end
	end

	// output register
	logic ok;
	assign ok = okd_q[DL-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vd_q[DL-1];
	end
	always_ff @(posedge clk) begin
		result.valid_res <= ok;
		result.r00 <= ok ? r[0] : '0;
		result.r01 <= ok ? r[1] : '0;
		result.r02 <= ok ? r[2] : '0;
		result.r10 <= ok ? r[3] : '0;
		result.r11 <= ok ? r[4] : '0;
		result.r12 <= ok ? r[5] : '0;
		result.r20 <= ok ? r[6] : '0;
		result.r21 <= ok ? r[7] : '0;
		result.r22 <= ok ? r[8] : '0;
	end

endmodule
